// ===== rtl/vpc_pkg.sv =====
package vpc_pkg;

    // timer rate in ticks per second
    localparam int unsigned TICK_HZ = 1000000;

    // serial multiplier: multiplicand, multiplier and product widths
    localparam int unsigned MUL_A_W = 64;
    localparam int unsigned MUL_B_W = 32;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W);

    // serial divider: dividend and divisor widths
    localparam int unsigned DIV_N_W = 68;
    localparam int unsigned DIV_D_W = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

    localparam logic [MUL_B_W-1:0] TICK_HZ_C = MUL_B_W'(TICK_HZ);
    localparam logic [DIV_D_W-1:0] TRAP_DIV_C = DIV_D_W'(2 * TICK_HZ);

    typedef enum logic [2:0] {
        REG_TARGET   = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_FEED_FWD = 3'd4,
        REG_DIST_PP  = 3'd5,
        REG_PERIOD   = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VMUL1,
        S_VMUL2,
        S_VDIV,
        S_ERR,
        S_IMUL,
        S_IDIV,
        S_IACC,
        S_DMUL,
        S_DDIV,
        S_GP,
        S_GI,
        S_GD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (x < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/vpc_mul.sv =====
module vpc_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  vpc_pkg::mul_req_t  req,
    output vpc_pkg::mul_rsp_t  rsp
);

    logic [vpc_pkg::MUL_A_W-1:0]   a_reg;
    logic [vpc_pkg::MUL_P_W-1:0]   acc_reg;
    logic [vpc_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [vpc_pkg::MUL_A_W:0]     sum;

    // one multiplier bit per cycle, product shifts right
    assign sum = {1'b0, acc_reg[vpc_pkg::MUL_P_W-1:vpc_pkg::MUL_B_W]}
               + (acc_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vpc_pkg::MUL_CNT_W'(vpc_pkg::MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.a;
            acc_reg <= {{vpc_pkg::MUL_A_W{1'b0}}, req.b};
        end else if (busy_reg) begin
            acc_reg <= {sum, acc_reg[vpc_pkg::MUL_B_W-1:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== rtl/vpc_div.sv =====
module vpc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  vpc_pkg::div_req_t  req,
    output vpc_pkg::div_rsp_t  rsp
);

    logic [vpc_pkg::DIV_N_W-1:0]   num_reg;
    logic [vpc_pkg::DIV_D_W-1:0]   rem_reg;
    logic [vpc_pkg::DIV_D_W-1:0]   den_reg;
    logic [vpc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [vpc_pkg::DIV_D_W:0]     trial;
    logic [vpc_pkg::DIV_D_W:0]     diff;
    logic                          ge;

    // restoring division, quotient bits shift in behind the dividend
    assign trial = {rem_reg, num_reg[vpc_pkg::DIV_N_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vpc_pkg::DIV_CNT_W'(vpc_pkg::DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[vpc_pkg::DIV_N_W-2:0], ge};
            rem_reg <= ge ? diff[vpc_pkg::DIV_D_W-1:0] : trial[vpc_pkg::DIV_D_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule

// ===== rtl/velocity_pid_controller.sv =====
// velocity pid controller: each input word carries a timer sample and an encoder
// position. the first word after reset only primes the stored time, count and
// previous error (loaded with the target). a later word whose elapsed ticks
// (mod 2^32) exceed update_period runs one control update: velocity from delta
// counts, error, trapezoidal integral (48-bit, saturated), derivative, and the
// gain products plus feed-forward, giving one result word with the update time,
// the saturated drive, its saturated negation and the measured velocity, the
// last three signed q16.16. words that prime or fall inside the period give
// nothing. an update makes seven passes through a 32-step bit-serial multiplier
// and three through a 68-step restoring divider, shared by all the multiply and
// divide steps of the calculation, plus the accept, error, integral clamp and
// output steps. the output step waits while an earlier result still sits unread
// in the output register. the input is held off during an update; a finished
// result waits in the output register and the next word is taken while it waits.
module velocity_pid_controller (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // sample_time[31:0], encoder_count[63:32]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // update_time[31:0], drive_level[63:32],
                                    // drive_mirrored[95:64], measured_velocity[127:96]
    // register writes
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    // configuration registers
    logic [31:0] target_reg, gain_p_reg, gain_i_reg, gain_d_reg, ff_reg;
    logic [31:0] dpp_reg, period_reg;

    // controller state
    logic        primed_reg, primed_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [31:0] prev_cnt_reg, prev_cnt_next;
    logic [31:0] prev_err_reg, prev_err_next;
    logic [47:0] integ_reg, integ_next;

    // update working registers
    vpc_pkg::state_t state_reg, state_next;
    logic        go_reg, go_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] dt_reg, dt_next;
    logic [32:0] dmag_reg, dmag_next;    // |encoder delta|
    logic        dneg_reg, dneg_next;
    logic [31:0] vel_reg, vel_next;
    logic [31:0] err_reg, err_next;
    logic [63:0] sum_reg, sum_next;

    // output register
    logic         m_tvalid_reg, m_tvalid_next;
    logic [127:0] m_tdata_reg, m_tdata_next;
    logic         out_load;

    vpc_pkg::mul_req_t mul_req;
    vpc_pkg::mul_rsp_t mul_rsp;
    vpc_pkg::div_req_t div_req;
    vpc_pkg::div_rsp_t div_rsp;
    logic              mul_start;
    logic              div_start;

    // combinational helpers
    logic        s_acc;
    logic [31:0] in_time, in_cnt, dt_c;
    logic [32:0] delta_c;
    logic [32:0] s33, s_mag, diff33, diff_mag;
    logic        s_neg, diff_neg;
    logic [47:0] integ_mag;
    logic [31:0] gain_sel, gain_mag;
    logic        x_neg, term_neg;
    logic [60:0] term_mag;
    logic [63:0] term;
    logic [67:0] vcap, vq;
    logic [31:0] vq32;
    logic [32:0] e33;
    logic [48:0] integ49;
    logic [43:0] inc_mag;
    logic [63:0] neg_sum;

    assign s_acc   = s_tvalid && s_tready;
    assign in_time = s_tdata[31:0];
    assign in_cnt  = s_tdata[63:32];
    assign dt_c    = in_time - last_time_reg;
    assign delta_c = {in_cnt[31], in_cnt} - {prev_cnt_reg[31], prev_cnt_reg};

    // trapezoid sum and difference of errors
    assign s33      = {prev_err_reg[31], prev_err_reg} + {err_reg[31], err_reg};
    assign s_neg    = s33[32];
    assign s_mag    = s_neg ? (~s33 + 1'b1) : s33;
    assign diff33   = {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};
    assign diff_neg = diff33[32];
    assign diff_mag = diff_neg ? (~diff33 + 1'b1) : diff33;
    assign integ_mag = integ_reg[47] ? (~integ_reg + 1'b1) : integ_reg;

    // gain product: |a|*|b| >> 16, capped at 2^60, sign applied
    always_comb begin
        case (state_reg)
            vpc_pkg::S_GP: begin
                gain_sel = gain_p_reg;
                x_neg    = err_reg[31];
            end
            vpc_pkg::S_GI: begin
                gain_sel = gain_i_reg;
                x_neg    = integ_reg[47];
            end
            default: begin
                gain_sel = gain_d_reg;
                x_neg    = diff_neg;
            end
        endcase
    end
    assign gain_mag = gain_sel[31] ? (~gain_sel + 1'b1) : gain_sel;
    assign term_neg = gain_sel[31] ^ x_neg;
    assign term_mag = (|mul_rsp.prod[95:76]) ? (61'd1 << 60) : {1'b0, mul_rsp.prod[75:16]};
    assign term     = term_neg ? (~{3'b0, term_mag} + 1'b1) : {3'b0, term_mag};

    // velocity quotient capped by direction
    assign vcap = dneg_reg ? 68'h8000_0000 : 68'h7fff_ffff;
    assign vq   = (div_rsp.quo > vcap) ? vcap : div_rsp.quo;
    assign vq32 = vq[31:0];

    assign e33     = {target_reg[31], target_reg} - {vel_reg[31], vel_reg};
    assign inc_mag = div_rsp.quo[43:0];
    assign integ49 = s_neg ? ({integ_reg[47], integ_reg} - {5'b0, inc_mag})
                           : ({integ_reg[47], integ_reg} + {5'b0, inc_mag});
    assign neg_sum = ~sum_reg + 1'b1;

    // shared arithmetic units
    vpc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    vpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // operand selection per step
    always_comb begin
        mul_req.start = mul_start;
        div_req.start = div_start;
        mul_req.a = '0;
        mul_req.b = '0;
        div_req.num = '0;
        div_req.den = dt_reg;
        case (state_reg)
            vpc_pkg::S_VMUL1: begin
                mul_req.a = {31'b0, dmag_reg};
                mul_req.b = dpp_reg;
            end
            vpc_pkg::S_VMUL2: begin
                mul_req.a = mul_rsp.prod[63:0];
                mul_req.b = vpc_pkg::TICK_HZ_C;
            end
            vpc_pkg::S_VDIV: begin
                div_req.num = mul_rsp.prod[83:16];
            end
            vpc_pkg::S_IMUL: begin
                mul_req.a = {31'b0, s_mag};
                mul_req.b = dt_reg;
            end
            vpc_pkg::S_IDIV: begin
                div_req.num = {4'b0, mul_rsp.prod[63:0]};
                div_req.den = vpc_pkg::TRAP_DIV_C;
            end
            vpc_pkg::S_DMUL: begin
                mul_req.a = {31'b0, diff_mag};
                mul_req.b = vpc_pkg::TICK_HZ_C;
            end
            vpc_pkg::S_DDIV: begin
                div_req.num = {16'b0, mul_rsp.prod[51:0]};
            end
            vpc_pkg::S_GP: begin
                mul_req.a = {32'b0, err_reg[31] ? (~err_reg + 1'b1) : err_reg};
                mul_req.b = gain_mag;
            end
            vpc_pkg::S_GI: begin
                mul_req.a = {16'b0, integ_mag};
                mul_req.b = gain_mag;
            end
            vpc_pkg::S_GD: begin
                mul_req.a = {12'b0, div_rsp.quo[51:0]};
                mul_req.b = gain_mag;
            end
            default: begin
                mul_req.a = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        go_next        = go_reg;
        primed_next    = primed_reg;
        last_time_next = last_time_reg;
        prev_cnt_next  = prev_cnt_reg;
        prev_err_next  = prev_err_reg;
        integ_next     = integ_reg;
        now_next       = now_reg;
        cnt_next       = cnt_reg;
        dt_next        = dt_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        vel_next       = vel_reg;
        err_next       = err_reg;
        sum_next       = sum_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        s_tready       = (state_reg == vpc_pkg::S_IDLE);

        case (state_reg)
            vpc_pkg::S_IDLE: begin
                if (s_acc) begin
                    if (!primed_reg) begin
                        primed_next    = 1'b1;
                        last_time_next = in_time;
                        prev_cnt_next  = in_cnt;
                        prev_err_next  = target_reg;
                    end else if (dt_c > period_reg) begin
                        now_next   = in_time;
                        cnt_next   = in_cnt;
                        dt_next    = dt_c;
                        dneg_next  = delta_c[32];
                        dmag_next  = delta_c[32] ? (~delta_c + 1'b1) : delta_c;
                        state_next = vpc_pkg::S_VMUL1;
                    end
                end
            end
            vpc_pkg::S_VMUL1, vpc_pkg::S_VMUL2, vpc_pkg::S_IMUL, vpc_pkg::S_DMUL,
            vpc_pkg::S_GP, vpc_pkg::S_GI, vpc_pkg::S_GD: begin
                if (!go_reg) begin
                    mul_start = 1'b1;
                    go_next   = 1'b1;
                end else if (mul_rsp.done) begin
                    go_next = 1'b0;
                    case (state_reg)
                        vpc_pkg::S_VMUL1: state_next = vpc_pkg::S_VMUL2;
                        vpc_pkg::S_VMUL2: state_next = vpc_pkg::S_VDIV;
                        vpc_pkg::S_IMUL:  state_next = vpc_pkg::S_IDIV;
                        vpc_pkg::S_DMUL:  state_next = vpc_pkg::S_DDIV;
                        vpc_pkg::S_GP: begin
                            sum_next   = sum_reg + term;
                            state_next = vpc_pkg::S_GI;
                        end
                        vpc_pkg::S_GI: begin
                            sum_next   = sum_reg + term;
                            state_next = vpc_pkg::S_GD;
                        end
                        default: begin
                            sum_next   = sum_reg + term;
                            state_next = vpc_pkg::S_OUT;
                        end
                    endcase
                end
            end
            vpc_pkg::S_VDIV, vpc_pkg::S_IDIV, vpc_pkg::S_DDIV: begin
                if (!go_reg) begin
                    div_start = 1'b1;
                    go_next   = 1'b1;
                end else if (div_rsp.done) begin
                    go_next = 1'b0;
                    case (state_reg)
                        vpc_pkg::S_VDIV: begin
                            vel_next   = dneg_reg ? (~vq32 + 1'b1) : vq32;
                            state_next = vpc_pkg::S_ERR;
                        end
                        vpc_pkg::S_IDIV: state_next = vpc_pkg::S_IACC;
                        default:         state_next = vpc_pkg::S_GP;
                    endcase
                end
            end
            vpc_pkg::S_ERR: begin
                err_next   = vpc_pkg::sat32({{31{e33[32]}}, e33});
                sum_next   = {{32{ff_reg[31]}}, ff_reg};
                state_next = vpc_pkg::S_IMUL;
            end
            vpc_pkg::S_IACC: begin
                // clamp to the 48-bit range
                if (!integ49[48] && integ49[47]) begin
                    integ_next = 48'h7fff_ffff_ffff;
                end else if (integ49[48] && !integ49[47]) begin
                    integ_next = 48'h8000_0000_0000;
                end else begin
                    integ_next = integ49[47:0];
                end
                state_next = vpc_pkg::S_DMUL;
            end
            vpc_pkg::S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load       = 1'b1;
                    last_time_next = now_reg;
                    prev_cnt_next  = cnt_reg;
                    prev_err_next  = err_reg;
                    state_next     = vpc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = vpc_pkg::S_IDLE;
                go_next    = 1'b0;
            end
        endcase
    end

    // result word
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {vel_reg, vpc_pkg::sat32(neg_sum),
                             vpc_pkg::sat32(sum_reg), now_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            ff_reg     <= '0;
            dpp_reg    <= 32'd596193;
            period_reg <= 32'd50000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                vpc_pkg::REG_TARGET:   target_reg <= cfg_wdata;
                vpc_pkg::REG_GAIN_P:   gain_p_reg <= cfg_wdata;
                vpc_pkg::REG_GAIN_I:   gain_i_reg <= cfg_wdata;
                vpc_pkg::REG_GAIN_D:   gain_d_reg <= cfg_wdata;
                vpc_pkg::REG_FEED_FWD: ff_reg     <= cfg_wdata;
                vpc_pkg::REG_DIST_PP:  dpp_reg    <= cfg_wdata;
                vpc_pkg::REG_PERIOD:   period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= vpc_pkg::S_IDLE;
            go_reg        <= 1'b0;
            primed_reg    <= 1'b0;
            last_time_reg <= '0;
            prev_cnt_reg  <= '0;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            primed_reg    <= primed_next;
            last_time_reg <= last_time_next;
            prev_cnt_reg  <= prev_cnt_next;
            prev_err_reg  <= prev_err_next;
            integ_reg     <= integ_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        cnt_reg     <= cnt_next;
        dt_reg      <= dt_next;
        dmag_reg    <= dmag_next;
        dneg_reg    <= dneg_next;
        vel_reg     <= vel_next;
        err_reg     <= err_next;
        sum_reg     <= sum_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // the two serial units never start together
    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_req.start && div_req.start))
        else $error("multiplier and divider started together");

    // a unit finishes only while the sequencer waits on it
    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_rsp.done || div_rsp.done) |-> go_reg)
        else $error("unit done without a pending step");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result word overwritten");

    // input held off during an update
    a_hold_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != vpc_pkg::S_IDLE) |-> !s_tready)
        else $error("input taken during an update");
`endif

endmodule
